// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// when cond holds, expr holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tbsm_pkg.sv =====
// Package for the text buffer substring move unit: sizes, codes and payload structs.
// No dependencies.
package tbsm_pkg;

    localparam int MAX_LEN = 4096;
    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       char_in;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic [7:0]       char_out;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
    } result_t;

endpackage

// ===== hw/rtl/text_buffer_substring_move_unit.sv =====
// Append, rejected items, unused codes, move onto itself: result in the cycle after the accept;
// read: registered memory read, then S_READ. Move: three in-place reversals over
// R = span + |dest - first|, one pair swap at a time on the memory's single read and write port.
// One item at a time: the next transfer can be taken in the cycle that shows the result.
// Reset clears length and control; memory contents are kept, not cleared.
// Depends on tbsm_pkg.
module text_buffer_substring_move_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tbsm_pkg::item_t  item,
    output logic             done,
    output tbsm_pkg::result_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FLIP
    } state_t;

    state_t                         state_reg;
    logic [tbsm_pkg::LEN_W-1:0]     len_reg;
    logic                           done_reg;
    tbsm_pkg::result_t              result_reg;
    logic [tbsm_pkg::LEN_W-1:0]     lo_reg;
    logic [tbsm_pkg::LEN_W-1:0]     hi_reg;
    logic [tbsm_pkg::LEN_W-1:0]     rl_reg;
    logic [tbsm_pkg::LEN_W-1:0]     rm_reg;
    logic [tbsm_pkg::LEN_W-1:0]     rh_reg;
    logic [1:0]                     flip_reg;
    logic                           ph_reg;
    logic                           pend_reg;
    logic [tbsm_pkg::IDX_W-1:0]     wlo_reg;
    logic [tbsm_pkg::IDX_W-1:0]     whi_reg;
    logic [7:0]                     tmp_reg;
    logic [7:0]                     rdata_reg;

    logic [7:0] text_mem [tbsm_pkg::MAX_LEN];

    logic                           accept;
    logic [tbsm_pkg::LEN_W-1:0]     first_x;
    logic [tbsm_pkg::LEN_W-1:0]     last_x;
    logic [tbsm_pkg::LEN_W-1:0]     dest_x;
    logic [tbsm_pkg::LEN_W-1:0]     span;
    logic                           bad_move;
    logic                           front;
    logic [tbsm_pkg::LEN_W-1:0]     mv_lo;
    logic [tbsm_pkg::LEN_W-1:0]     mv_mid;
    logic [tbsm_pkg::LEN_W-1:0]     mv_hi;
    logic [tbsm_pkg::LEN_W-1:0]     hi_m1;
    logic                           issue;
    logic                           not_full;

    logic                           mem_we;
    logic [tbsm_pkg::IDX_W-1:0]     mem_waddr;
    logic [7:0]                     mem_wdata;
    logic [tbsm_pkg::IDX_W-1:0]     mem_raddr;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    assign first_x  = {1'b0, item.first};
    assign last_x   = {1'b0, item.last};
    assign dest_x   = {1'b0, item.dest};
    assign span     = last_x - first_x + tbsm_pkg::LEN_W'(1);
    assign bad_move = (first_x > last_x) || (last_x >= len_reg) || (dest_x > len_reg - span);
    assign front    = (dest_x < first_x);
    assign mv_lo    = front ? dest_x : first_x;
    assign mv_mid   = front ? first_x : last_x + tbsm_pkg::LEN_W'(1);
    assign mv_hi    = front ? last_x + tbsm_pkg::LEN_W'(1) : dest_x + span;
    assign not_full = (len_reg < tbsm_pkg::LEN_W'(tbsm_pkg::MAX_LEN));

    assign hi_m1 = hi_reg - tbsm_pkg::LEN_W'(1);
    assign issue = (lo_reg + tbsm_pkg::LEN_W'(1)) < hi_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = len_reg[tbsm_pkg::IDX_W-1:0];
        mem_wdata = item.char_in;
        mem_raddr = item.read_index;
        if (state_reg == S_FLIP)
        begin
            mem_we = pend_reg;
            if (!ph_reg)
            begin
                mem_raddr = lo_reg[tbsm_pkg::IDX_W-1:0];
                mem_waddr = wlo_reg;
                mem_wdata = rdata_reg;
            end
            else
            begin
                mem_raddr = hi_m1[tbsm_pkg::IDX_W-1:0];
                mem_waddr = whi_reg;
                mem_wdata = tmp_reg;
            end
        end
        else if (accept && item.op == tbsm_pkg::OP_APPEND && not_full)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= text_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            rl_reg     <= '0;
            rm_reg     <= '0;
            rh_reg     <= '0;
            flip_reg   <= '0;
            ph_reg     <= 1'b0;
            pend_reg   <= 1'b0;
            wlo_reg    <= '0;
            whi_reg    <= '0;
            tmp_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg <= '{char_out: 8'd0, status: tbsm_pkg::ST_OK,
                                        length: len_reg};
                        case (item.op)
                            tbsm_pkg::OP_APPEND:
                            begin
                                done_reg <= 1'b1;
                                if (not_full)
                                begin
                                    len_reg           <= len_reg + tbsm_pkg::LEN_W'(1);
                                    result_reg.length <= len_reg + tbsm_pkg::LEN_W'(1);
                                end
                                else
                                begin
                                    result_reg.status <= tbsm_pkg::ST_FULL;
                                end
                            end
                            tbsm_pkg::OP_MOVE:
                            begin
                                if (bad_move)
                                begin
                                    done_reg          <= 1'b1;
                                    result_reg.status <= tbsm_pkg::ST_RANGE;
                                end
                                else if (dest_x == first_x)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_FLIP;
                                    rl_reg    <= mv_lo;
                                    rm_reg    <= mv_mid;
                                    rh_reg    <= mv_hi;
                                    lo_reg    <= mv_lo;
                                    hi_reg    <= mv_mid;
                                    flip_reg  <= 2'd0;
                                    ph_reg    <= 1'b0;
                                    pend_reg  <= 1'b0;
                                end
                            end
                            tbsm_pkg::OP_READ:
                            begin
                                if ({1'b0, item.read_index} < len_reg)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    done_reg          <= 1'b1;
                                    result_reg.status <= tbsm_pkg::ST_RANGE;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    result_reg.char_out <= rdata_reg;
                    done_reg            <= 1'b1;
                    state_reg           <= S_IDLE;
                end
                S_FLIP:
                begin
                    if (!ph_reg)
                    begin
                        ph_reg <= 1'b1;
                    end
                    else
                    begin
                        // pair read in this round becomes the pending write pair
                        ph_reg   <= 1'b0;
                        tmp_reg  <= rdata_reg;
                        wlo_reg  <= lo_reg[tbsm_pkg::IDX_W-1:0];
                        whi_reg  <= hi_m1[tbsm_pkg::IDX_W-1:0];
                        pend_reg <= issue;
                        if (issue)
                        begin
                            lo_reg <= lo_reg + tbsm_pkg::LEN_W'(1);
                            hi_reg <= hi_m1;
                        end
                        else if (flip_reg == 2'd2)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            flip_reg <= flip_reg + 2'd1;
                            lo_reg   <= (flip_reg == 2'd0) ? rm_reg : rl_reg;
                            hi_reg   <= rh_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/tbsm_checker.sv =====
// Port-level checker for the text buffer substring move unit, bound to the top level.
// Depends on tbsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbsm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input tbsm_pkg::item_t   item,
    input logic              done,
    input tbsm_pkg::result_t result
);

    logic [tbsm_pkg::LEN_W-1:0] max_len;
    assign max_len = tbsm_pkg::LEN_W'(tbsm_pkg::MAX_LEN);

    `ASSERT_CLK(a_accept_leads_on, clk, rst_n, (start && !busy) |=> (busy || done))
    `ASSERT_CLK(a_busy_from_accept, clk, rst_n, $rose(busy) |-> $past(start))
    `ASSERT_IMPL(a_len_bound, clk, rst_n, done, result.length <= max_len)
    `ASSERT_IMPL(a_char_only_ok, clk, rst_n, done,
        (result.char_out == 8'd0) || (result.status == tbsm_pkg::ST_OK))
    `ASSERT_IMPL(a_full_at_max, clk, rst_n, done && (result.status == tbsm_pkg::ST_FULL),
        result.length == max_len)

endmodule

bind text_buffer_substring_move_unit tbsm_checker u_tbsm_checker (.*);
